/* rtl/hls2rgb_pkg.sv */
// Shared constants for the HLS to RGB converter: hue sector codes,
// hue scale constants and default parameter values. No dependencies.
package hls2rgb_pkg;

   localparam int FRAC_BITS_DEF = 15;

   // hue in 1/64 degree units
   localparam int HUE_W    = 15;
   localparam int NUM_W    = 13;
   localparam int HUE_FULL = 23040;
   localparam int HUE_30   = 1920;
   localparam int HUE_60   = 3840;
   localparam int HUE_120  = 7680;

   // every sector width is 15 * 2^k
   localparam int DEN_BASE  = 15;
   localparam int SHIFT_30  = 7;
   localparam int SHIFT_60  = 8;
   localparam int SHIFT_120 = 9;

   // sector width codes
   localparam logic [1:0] DEN_30  = 2'd0;
   localparam logic [1:0] DEN_60  = 2'd1;
   localparam logic [1:0] DEN_120 = 2'd2;

   // hue sectors
   localparam logic [2:0] SEC_R_TO_Y = 3'd0;
   localparam logic [2:0] SEC_Y_TO_G = 3'd1;
   localparam logic [2:0] SEC_G_TO_C = 3'd2;
   localparam logic [2:0] SEC_C_TO_B = 3'd3;
   localparam logic [2:0] SEC_B_TO_M = 3'd4;
   localparam logic [2:0] SEC_M_TO_R = 3'd5;

endpackage

/* rtl/hls_to_rgb_converter.sv */
// HLS to RGB converter, six-stage pipeline, top level.
// Depends on hls2rgb_pkg for sector codes and hue constants.
//
// Usage:
//   req_* takes one request per cycle while req_tready is high: tdata =
//   {saturation, lightness, hue} from the top bit down, hue in 1/64 degree,
//   lightness and saturation unsigned with FRAC_BITS fraction bits (1.0 = 1 << FRAC_BITS).
//   rsp_* returns {blue, green, red} in the same format, one per request,
//   in order.
//   csr_* writes hue_mode (1 uniform 60 degree sectors, 0 warped mapping);
//   write it only while no request is in flight. csr_ready is always high.
//   A request accepted on req_* passes in order through the six register
//   stages (hue reduce, sector select and l*s multiply, max/min levels,
//   ramp multiplies, reciprocal multiply, correction/mux) to rsp_tdata.
//   Throughput: one request per cycle while rsp_tready stays high.
//   Each stage holds its own valid bit; a stage loads whenever it is empty
//   or the one after it moves, so bubbles close up and req_tready stays
//   high while a finished result waits as long as a stage is free.
//   When rsp_tready is low the pipeline fills and then holds; nothing is
//   dropped or repeated.
//   Reset clears all valid bits and sets hue_mode to 1.
module hls_to_rgb_converter #(
   parameter int FRAC_BITS = hls2rgb_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // hue[15:0], lightness[31:16], saturation[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red[15:0], green[31:16], blue[47:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_data     // hue_mode
);

   localparam int LW  = FRAC_BITS + 1;            // holds 1.0
   localparam int CW  = (LW > 16) ? LW : 16;      // compare width vs 16-bit ports
   localparam int XW  = LW + hls2rgb_pkg::NUM_W;  // diff * num
   localparam int YW  = XW + 1;
   localparam int ZW  = FRAC_BITS + 4;            // quotient by 2^k, below 15 * (diff + 1)
   localparam int RW  = ZW - 3;
   localparam int PW  = ZW + RW;
   localparam int HW  = hls2rgb_pkg::HUE_W;
   localparam int NW  = hls2rgb_pkg::NUM_W;
   localparam longint unsigned RECIP_VAL = (64'd1 << ZW) / hls2rgb_pkg::DEN_BASE;
   localparam logic [RW-1:0] RECIP = RW'(RECIP_VAL);
   localparam logic [LW-1:0] ONE   = LW'(1) << FRAC_BITS;
   localparam logic [LW-1:0] HALF  = LW'(1) << (FRAC_BITS - 1);

   function automatic logic [15:0] sat16(input logic [LW-1:0] v);
      logic [CW-1:0] e;
      e = CW'(v);
      return (e > CW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
   endfunction

   // mini + round(diff * num / den) from z = (diff*num + den/2) >> k and z * RECIP
   function automatic logic [LW-1:0] ramp_fin(input logic [ZW-1:0] z,
                                              input logic [PW-1:0] zm,
                                              input logic [LW-1:0] mini);
      logic [LW-1:0] q0;
      logic [ZW-1:0] q15;
      logic [ZW-1:0] rem;
      logic [LW-1:0] q;
      logic [LW:0]   sum;
      q0  = zm[ZW +: LW];
      q15 = (ZW'(q0) << 4) - ZW'(q0);
      rem = z - q15;
      q   = q0 + LW'(rem >= ZW'(hls2rgb_pkg::DEN_BASE));
      sum = {1'b0, mini} + {1'b0, q};
      return sum[LW-1:0];
   endfunction

   // configuration
   logic hue_mode_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_mode_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         hue_mode_ff <= csr_data[0];
      end
   end

   // stage enables: load when empty or when the next stage moves
   logic en1, en2, en3, en4, en5, en6;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   assign en6 = !v6_ff || rsp_tready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // ---------------- stage 1: hue modulo 360, clamp l and s
   logic [15:0]   hue_w, l_raw, s_raw;
   logic [15:0]   hue_red;
   logic [HW-1:0] hm1_in, hm1_ff;
   logic [LW-1:0] l1_in, l1_ff, s1_in, s1_ff;

   always_comb begin
      hue_w = req_tdata[15:0];
      l_raw = req_tdata[31:16];
      s_raw = req_tdata[47:32];
      if (hue_w >= 16'(2 * hls2rgb_pkg::HUE_FULL)) begin
         hue_red = hue_w - 16'(2 * hls2rgb_pkg::HUE_FULL);
      end else if (hue_w >= 16'(hls2rgb_pkg::HUE_FULL)) begin
         hue_red = hue_w - 16'(hls2rgb_pkg::HUE_FULL);
      end else begin
         hue_red = hue_w;
      end
      hm1_in = hue_red[HW-1:0];
      l1_in  = (CW'(l_raw) > CW'(ONE)) ? ONE : LW'(l_raw);
      s1_in  = (CW'(s_raw) > CW'(ONE)) ? ONE : LW'(s_raw);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         hm1_ff <= hm1_in;
         l1_ff  <= l1_in;
         s1_ff  <= s1_in;
      end
   end

   // ---------------- stage 2: sector and fraction, l * s
   logic [2:0]      sec2_in, sec2_ff;
   logic [NW-1:0]   num2_in, num2_ff;
   logic [1:0]      dc2_in, dc2_ff;
   logic [LW-1:0]   l2_ff, s2_ff;
   logic [2*LW-1:0] ls2_in, ls2_ff;
   logic [HW-1:0]   off2;

   always_comb begin
      off2 = hm1_ff - HW'(3 * hls2rgb_pkg::HUE_60);
      if (hue_mode_ff) begin
         dc2_in = hls2rgb_pkg::DEN_60;
         if (hm1_ff >= HW'(5 * hls2rgb_pkg::HUE_60)) begin
            sec2_in = hls2rgb_pkg::SEC_M_TO_R;
            num2_in = NW'(hm1_ff - HW'(5 * hls2rgb_pkg::HUE_60));
         end else if (hm1_ff >= HW'(4 * hls2rgb_pkg::HUE_60)) begin
            sec2_in = hls2rgb_pkg::SEC_B_TO_M;
            num2_in = NW'(hm1_ff - HW'(4 * hls2rgb_pkg::HUE_60));
         end else if (hm1_ff >= HW'(3 * hls2rgb_pkg::HUE_60)) begin
            sec2_in = hls2rgb_pkg::SEC_C_TO_B;
            num2_in = NW'(off2);
         end else if (hm1_ff >= HW'(2 * hls2rgb_pkg::HUE_60)) begin
            sec2_in = hls2rgb_pkg::SEC_G_TO_C;
            num2_in = NW'(hm1_ff - HW'(2 * hls2rgb_pkg::HUE_60));
         end else if (hm1_ff >= HW'(hls2rgb_pkg::HUE_60)) begin
            sec2_in = hls2rgb_pkg::SEC_Y_TO_G;
            num2_in = NW'(hm1_ff - HW'(hls2rgb_pkg::HUE_60));
         end else begin
            sec2_in = hls2rgb_pkg::SEC_R_TO_Y;
            num2_in = NW'(hm1_ff);
         end
      end else begin
         if (hm1_ff < HW'(hls2rgb_pkg::HUE_120)) begin
            sec2_in = hls2rgb_pkg::SEC_R_TO_Y;
            num2_in = NW'(hm1_ff);
            dc2_in  = hls2rgb_pkg::DEN_120;
         end else if (hm1_ff < HW'(3 * hls2rgb_pkg::HUE_60)) begin
            sec2_in = hls2rgb_pkg::SEC_Y_TO_G;
            num2_in = NW'(hm1_ff - HW'(hls2rgb_pkg::HUE_120));
            dc2_in  = hls2rgb_pkg::DEN_60;
         end else if (hm1_ff < HW'(4 * hls2rgb_pkg::HUE_60)) begin
            // green to blue squeezed into two 30 degree halves
            dc2_in = hls2rgb_pkg::DEN_30;
            if (off2 < HW'(hls2rgb_pkg::HUE_30)) begin
               sec2_in = hls2rgb_pkg::SEC_G_TO_C;
               num2_in = NW'(off2);
            end else begin
               sec2_in = hls2rgb_pkg::SEC_C_TO_B;
               num2_in = NW'(off2 - HW'(hls2rgb_pkg::HUE_30));
            end
         end else if (hm1_ff >= HW'(5 * hls2rgb_pkg::HUE_60)) begin
            sec2_in = hls2rgb_pkg::SEC_M_TO_R;
            num2_in = NW'(hm1_ff - HW'(5 * hls2rgb_pkg::HUE_60));
            dc2_in  = hls2rgb_pkg::DEN_60;
         end else begin
            sec2_in = hls2rgb_pkg::SEC_B_TO_M;
            num2_in = NW'(hm1_ff - HW'(4 * hls2rgb_pkg::HUE_60));
            dc2_in  = hls2rgb_pkg::DEN_60;
         end
      end
      ls2_in = (2*LW)'(l1_ff) * (2*LW)'(s1_ff);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         sec2_ff <= sec2_in;
         num2_ff <= num2_in;
         dc2_ff  <= dc2_in;
         l2_ff   <= l1_ff;
         s2_ff   <= s1_ff;
         ls2_ff  <= ls2_in;
      end
   end

   // ---------------- stage 3: max / min levels
   logic [2*LW-1:0] ls_rnd;
   logic [LW-1:0]   prod3;
   logic [LW:0]     lps3, maxi_w, two_l, mini_w;
   logic [LW-1:0]   maxi3_in, mini3_in, diff3_in;
   logic [NW-1:0]   den3, dnum3_in;
   logic [2:0]      sec3_ff;
   logic [NW-1:0]   num3_ff, dnum3_ff;
   logic [1:0]      dc3_ff;
   logic [LW-1:0]   l3_ff, maxi3_ff, mini3_ff, diff3_ff;
   logic            sz3_ff;

   always_comb begin
      ls_rnd = ls2_ff + (2*LW)'(HALF);
      prod3  = ls_rnd[FRAC_BITS +: LW];
      lps3   = {1'b0, l2_ff} + {1'b0, s2_ff};
      if (l2_ff <= HALF) begin
         maxi_w = {1'b0, l2_ff} + {1'b0, prod3};
      end else if (lps3 > {1'b0, prod3}) begin
         maxi_w = lps3 - {1'b0, prod3};
      end else begin
         maxi_w = '0;
      end
      maxi3_in = (maxi_w > {1'b0, ONE}) ? ONE : maxi_w[LW-1:0];
      two_l    = {l2_ff, 1'b0};
      mini_w   = (two_l > {1'b0, maxi3_in}) ? two_l - {1'b0, maxi3_in} : '0;
      mini3_in = (mini_w > {1'b0, maxi3_in}) ? maxi3_in : mini_w[LW-1:0];
      diff3_in = maxi3_in - mini3_in;
      case (dc2_ff)
         hls2rgb_pkg::DEN_30:  den3 = NW'(hls2rgb_pkg::HUE_30);
         hls2rgb_pkg::DEN_120: den3 = NW'(hls2rgb_pkg::HUE_120);
         default:              den3 = NW'(hls2rgb_pkg::HUE_60);
      endcase
      dnum3_in = den3 - num2_ff;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         sec3_ff  <= sec2_ff;
         num3_ff  <= num2_ff;
         dnum3_ff <= dnum3_in;
         dc3_ff   <= dc2_ff;
         l3_ff    <= l2_ff;
         sz3_ff   <= (s2_ff == '0);
         maxi3_ff <= maxi3_in;
         mini3_ff <= mini3_in;
         diff3_ff <= diff3_in;
      end
   end

   // ---------------- stage 4: ramp numerators
   logic [2:0]    sec4_ff;
   logic [1:0]    dc4_ff;
   logic [LW-1:0] l4_ff, maxi4_ff, mini4_ff;
   logic          sz4_ff;
   logic [XW-1:0] xup4_in, xdn4_in, xup4_ff, xdn4_ff;

   assign xup4_in = XW'(diff3_ff) * XW'(num3_ff);
   assign xdn4_in = XW'(diff3_ff) * XW'(dnum3_ff);

   always_ff @(posedge clock) begin
      if (en4) begin
         sec4_ff  <= sec3_ff;
         dc4_ff   <= dc3_ff;
         l4_ff    <= l3_ff;
         sz4_ff   <= sz3_ff;
         maxi4_ff <= maxi3_ff;
         mini4_ff <= mini3_ff;
         xup4_ff  <= xup4_in;
         xdn4_ff  <= xdn4_in;
      end
   end

   // ---------------- stage 5: round, strip 2^k, multiply by 1/15
   logic [YW-1:0] half5, yup5, ydn5;
   logic [ZW-1:0] zup5_in, zdn5_in, zup5_ff, zdn5_ff;
   logic [PW-1:0] mup5_in, mdn5_in, mup5_ff, mdn5_ff;
   logic [2:0]    sec5_ff;
   logic [LW-1:0] l5_ff, maxi5_ff, mini5_ff;
   logic          sz5_ff;

   always_comb begin
      case (dc4_ff)
         hls2rgb_pkg::DEN_30:  half5 = YW'(hls2rgb_pkg::HUE_30 / 2);
         hls2rgb_pkg::DEN_120: half5 = YW'(hls2rgb_pkg::HUE_120 / 2);
         default:              half5 = YW'(hls2rgb_pkg::HUE_60 / 2);
      endcase
      yup5 = {1'b0, xup4_ff} + half5;
      ydn5 = {1'b0, xdn4_ff} + half5;
      case (dc4_ff)
         hls2rgb_pkg::DEN_30: begin
            zup5_in = ZW'(yup5 >> hls2rgb_pkg::SHIFT_30);
            zdn5_in = ZW'(ydn5 >> hls2rgb_pkg::SHIFT_30);
         end
         hls2rgb_pkg::DEN_120: begin
            zup5_in = ZW'(yup5 >> hls2rgb_pkg::SHIFT_120);
            zdn5_in = ZW'(ydn5 >> hls2rgb_pkg::SHIFT_120);
         end
         default: begin
            zup5_in = ZW'(yup5 >> hls2rgb_pkg::SHIFT_60);
            zdn5_in = ZW'(ydn5 >> hls2rgb_pkg::SHIFT_60);
         end
      endcase
      mup5_in = PW'(zup5_in) * PW'(RECIP);
      mdn5_in = PW'(zdn5_in) * PW'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         sec5_ff  <= sec4_ff;
         l5_ff    <= l4_ff;
         sz5_ff   <= sz4_ff;
         maxi5_ff <= maxi4_ff;
         mini5_ff <= mini4_ff;
         zup5_ff  <= zup5_in;
         zdn5_ff  <= zdn5_in;
         mup5_ff  <= mup5_in;
         mdn5_ff  <= mdn5_in;
      end
   end

   // ---------------- stage 6: quotient correction, channel select, output register
   logic [LW-1:0] up6, down6, r6, g6, b6;
   logic [15:0]   red6_in, green6_in, blue6_in;
   logic [15:0]   red6_ff, green6_ff, blue6_ff;

   always_comb begin
      up6   = ramp_fin(zup5_ff, mup5_ff, mini5_ff);
      down6 = ramp_fin(zdn5_ff, mdn5_ff, mini5_ff);
      case (sec5_ff)
         hls2rgb_pkg::SEC_R_TO_Y: begin r6 = maxi5_ff; g6 = up6;      b6 = mini5_ff; end
         hls2rgb_pkg::SEC_Y_TO_G: begin r6 = down6;    g6 = maxi5_ff; b6 = mini5_ff; end
         hls2rgb_pkg::SEC_G_TO_C: begin r6 = mini5_ff; g6 = maxi5_ff; b6 = up6;      end
         hls2rgb_pkg::SEC_C_TO_B: begin r6 = mini5_ff; g6 = down6;    b6 = maxi5_ff; end
         hls2rgb_pkg::SEC_B_TO_M: begin r6 = up6;      g6 = mini5_ff; b6 = maxi5_ff; end
         default:                 begin r6 = maxi5_ff; g6 = mini5_ff; b6 = down6;    end
      endcase
      if (sz5_ff) begin
         r6 = l5_ff;
         g6 = l5_ff;
         b6 = l5_ff;
      end
      red6_in   = sat16(r6);
      green6_in = sat16(g6);
      blue6_in  = sat16(b6);
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         red6_ff   <= red6_in;
         green6_ff <= green6_in;
         blue6_ff  <= blue6_in;
      end
   end

   assign rsp_tvalid = v6_ff;
   assign rsp_tdata  = {blue6_ff, green6_ff, red6_ff};

endmodule

/* verif/hls_rgb_checker.sv */
// Checker for the HLS to RGB converter: watches the request, response and CSR
// channels, predicts each response in fixed point and compares it.
// Depends on hls2rgb_pkg for hue constants and sector codes.
module hls_rgb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // hue[15:0], lightness[31:16], saturation[47:32]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // red[15:0], green[31:16], blue[47:32]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [0:0]  csr_data,    // hue_mode
   output int          mismatches,
   output int          outstanding
);

   localparam int FRAC = hls2rgb_pkg::FRAC_BITS_DEF;

   typedef struct packed {
      logic [15:0] saturation;
      logic [15:0] lightness;
      logic [15:0] hue;
   } hls_type;

   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } rgb_type;

   typedef struct {
      hls_type px;
      rgb_type rgb;
   } rgb_expect_type;

   rgb_expect_type rgb_queue[$];
   bit             uniform_hue;

   function automatic rgb_type convert_hls(hls_type px, bit uniform);
      longint unsigned one, half, hm, l, s, sector, num, den, off;
      longint unsigned prod, hi, lo, span, rise, fall, r, g, b;
      rgb_type c;
      one  = 64'd1 << FRAC;
      half = one >> 1;
      hm = px.hue % hls2rgb_pkg::HUE_FULL;
      l  = (px.lightness > one) ? one : px.lightness;
      s  = (px.saturation > one) ? one : px.saturation;
      // warped mode differs only below 240 degrees
      if (uniform || hm >= 4 * hls2rgb_pkg::HUE_60) begin
         sector = hm / hls2rgb_pkg::HUE_60;
         num    = hm % hls2rgb_pkg::HUE_60;
         den    = hls2rgb_pkg::HUE_60;
      end else if (hm < hls2rgb_pkg::HUE_120) begin
         sector = hls2rgb_pkg::SEC_R_TO_Y;
         num    = hm;
         den    = hls2rgb_pkg::HUE_120;
      end else if (hm < 3 * hls2rgb_pkg::HUE_60) begin
         sector = hls2rgb_pkg::SEC_Y_TO_G;
         num    = hm - hls2rgb_pkg::HUE_120;
         den    = hls2rgb_pkg::HUE_60;
      end else begin
         off    = hm - 3 * hls2rgb_pkg::HUE_60;
         sector = hls2rgb_pkg::SEC_G_TO_C + off / hls2rgb_pkg::HUE_30;
         num    = off % hls2rgb_pkg::HUE_30;
         den    = hls2rgb_pkg::HUE_30;
      end
      prod = (l * s + half) >> FRAC;
      if (l <= half)
         hi = l + prod;
      else
         hi = (l + s > prod) ? l + s - prod : 0;
      if (hi > one)
         hi = one;
      lo = (2 * l > hi) ? 2 * l - hi : 0;
      if (lo > hi)
         lo = hi;
      span = hi - lo;
      rise = lo + (span * num + den / 2) / den;
      fall = lo + (span * (den - num) + den / 2) / den;
      if (s == 0) begin
         r = l; g = l; b = l;
      end else begin
         case (sector[2:0])
            hls2rgb_pkg::SEC_R_TO_Y: begin r = hi;   g = rise; b = lo;   end
            hls2rgb_pkg::SEC_Y_TO_G: begin r = fall; g = hi;   b = lo;   end
            hls2rgb_pkg::SEC_G_TO_C: begin r = lo;   g = hi;   b = rise; end
            hls2rgb_pkg::SEC_C_TO_B: begin r = lo;   g = fall; b = hi;   end
            hls2rgb_pkg::SEC_B_TO_M: begin r = rise; g = lo;   b = hi;   end
            default:                 begin r = hi;   g = lo;   b = fall; end
         endcase
      end
      c.red   = (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
      c.green = (g > 64'hFFFF) ? 16'hFFFF : g[15:0];
      c.blue  = (b > 64'hFFFF) ? 16'hFFFF : b[15:0];
      return c;
   endfunction

   always @(posedge clock) begin
      rgb_expect_type e;
      rgb_type        got;
      if (reset) begin
         rgb_queue.delete();
         uniform_hue = 1'b1;
      end else begin
         if (csr_valid && csr_ready)
            uniform_hue = csr_data[0];
         if (req_tvalid && req_tready) begin
            e.px  = req_tdata;
            e.rgb = convert_hls(req_tdata, uniform_hue);
            rgb_queue.insert(rgb_queue.size(), e);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (rgb_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response r=%0d g=%0d b=%0d",
                           got.red, got.green, got.blue);
            end else begin
               e = rgb_queue.pop_front();
               if (got.red !== e.rgb.red || got.green !== e.rgb.green ||
                   got.blue !== e.rgb.blue) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch h=%0d l=%0d s=%0d mode=%0d: ",
                               "exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d"},
                              e.px.hue, e.px.lightness, e.px.saturation,
                              uniform_hue,
                              e.rgb.red, e.rgb.green, e.rgb.blue,
                              got.red, got.green, got.blue);
               end
            end
         end
      end
      outstanding = rgb_queue.size();
   end

endmodule

/* verif/tb_top.sv */
// Testbench top for the HLS to RGB converter: clock, reset, request and CSR
// stimulus, response backpressure and the verdict.
// Depends on hls_to_rgb_converter, hls2rgb_pkg and hls_rgb_checker.
module tb_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_data = '0;

   int mismatches;
   int outstanding;
   int cycles      = 0;
   int send_idle   = 0;
   int recv_idle   = 0;
   int hold_len    = 0;
   int hold_req    = 0;

   always #1 clock = ~clock;

   hls_to_rgb_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   hls_rgb_checker rgb_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // response side: random backpressure, plus a long hold when requested
   initial begin
      int stall_left;
      int hold_seen;
      stall_left = 0;
      hold_seen  = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_req) begin
            hold_seen  = hold_req;
            stall_left = hold_len;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic send_hls(input logic [15:0] hue, input logic [15:0] l,
                           input logic [15:0] s);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s, l, hue};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // only while idle: every request has had its response
   task automatic write_hue_mode(input bit uniform);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= uniform;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // corners of the Q1.15 range, out-of-range values now and then
   function automatic logic [15:0] rand_level();
      int unsigned k;
      k = $urandom_range(15);
      if (k == 0)
         return 16'd0;
      if (k == 1)
         return 16'd32768;
      if (k == 2)
         return 16'($urandom_range(65535));
      return 16'($urandom_range(32768));
   endfunction

   task automatic send_random(input int count);
      logic [15:0] hue;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1))
            hue = 16'($urandom_range(hls2rgb_pkg::HUE_FULL - 1));
         else
            hue = 16'($urandom_range(65535));
         send_hls(hue, rand_level(), rand_level());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // uniform sectors after reset
      send_hls(16'd0,     16'd16384, 16'd32768);
      send_hls(16'd65535, 16'd32768, 16'd32768);
      send_hls(16'd23040, 16'd16384, 16'd32768);
      send_hls(16'd23039, 16'd16385, 16'd20000);
      send_hls(16'd5760,  16'd12000, 16'd30000);
      send_hls(16'd9600,  16'd20000, 16'd1);
      send_hls(16'd13440, 16'd0,     16'd32768);
      send_hls(16'd17280, 16'd16384, 16'd0);
      send_hls(16'd21120, 16'd65535, 16'd65535);
      send_hls(16'd3840,  16'd16384, 16'd16384);
      send_hls(16'd1000,  16'd32767, 16'd32767);
      send_hls(16'd46180, 16'd8000,  16'd24000);

      // warped mapping, sector edges
      write_hue_mode(1'b0);
      send_hls(16'd7679,  16'd16384, 16'd32768);
      send_hls(16'd7680,  16'd16384, 16'd32768);
      send_hls(16'd11519, 16'd10000, 16'd30000);
      send_hls(16'd11520, 16'd22000, 16'd18000);
      send_hls(16'd13439, 16'd16384, 16'd32768);
      send_hls(16'd13440, 16'd16384, 16'd32768);
      send_hls(16'd15359, 16'd30000, 16'd5000);
      send_hls(16'd15360, 16'd16384, 16'd32768);
      send_hls(16'd0,     16'd65535, 16'd12345);
      send_hls(16'd65535, 16'd16384, 16'd32768);

      write_hue_mode(1'b1);
      send_idle = 18;
      recv_idle = 77;
      send_random(150);

      write_hue_mode(1'b0);
      send_idle = 77;
      recv_idle = 18;
      send_random(150);

      // no idling; a long response hold fills the pipe and stalls requests
      write_hue_mode(1'b1);
      send_idle = 0;
      recv_idle = 0;
      hold_len  = 300;
      hold_req++;
      send_random(75);
      write_hue_mode(1'b0);
      hold_len  = 200;
      hold_req++;
      send_random(75);

      drain();
      if (mismatches == 0 && outstanding == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

/* hls_to_rgb_converter.f */
rtl/hls2rgb_pkg.sv
rtl/hls_to_rgb_converter.sv
verif/hls_rgb_checker.sv
verif/tb_top.sv
